>>> rtl/cpuc_pkg.sv
// shared constants and types of the clock period unit converter
package cpuc_pkg;

  localparam int unsigned AmountW  = 64;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned HalfW    = AmountW / 2;
  localparam int unsigned CellBits = 4;
  localparam int unsigned NumCells = AmountW / CellBits;
  localparam int unsigned ActionW  = 2;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [HalfW-1:0] HzPerGhz = 32'd1000000000;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgInfoPresent = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCoreNum     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCoreDen     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRefNum      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRefDen      = 3'd4;

  typedef enum logic [ActionW-1:0] {
    ActCyclesToNs = 2'd0,
    ActNsToCycles = 2'd1,
    ActFreq       = 2'd2
  } action_e;

  typedef struct packed {
    logic               info_present;
    logic [PeriodW-1:0] core_num;
    logic [PeriodW-1:0] core_den;
    logic [PeriodW-1:0] ref_num;
    logic [PeriodW-1:0] ref_den;
  } cfg_t;

  // partial products after the first multiply stage
  typedef struct packed {
    logic [HalfW+PeriodW-1:0] lo;
    logic [HalfW-1:0]         hi;
    logic [PeriodW-1:0]       div;
    logic                     zero;
    logic                     mask;
  } mul_t;

  // divider word: dividend shifts out at the top, quotient bits shift in
  typedef struct packed {
    logic [AmountW-1:0] dvd;
    logic [PeriodW-1:0] rem;
    logic [PeriodW-1:0] div;
    logic               zero;
    logic               mask;
  } div_t;

endpackage

>>> rtl/clock_period_unit_converter_unit.sv
// clock period unit converter: cycles <-> ns and nominal frequency, pipelined
//
// input channel (in_valid_i/in_ready_o) takes one word per cycle while in_ready_o is
// high: action_i, clock_select_i and amount_i. each word gives exactly one result
// word on the output channel (out_valid_o/out_ready_i) carrying converted_o, in order.
// from acceptance to out_valid_o a word passes two multiply stages
// (64x16 product split into two 32x16 halves, then summed mod 2^64) and
// 16 divider cells, each resolving 4 quotient bits of the 64-bit dividend
// by a 16-bit divisor. throughput is one word per cycle unless a stalled receiver fills every stage.
// configuration is written through cfg_valid_i/cfg_index_i/cfg_data_i,
// always ready; writes are expected only while no word is in flight.
// reset clears the configuration registers to zero (info absent, so results
// read 0) and empties the pipeline. when the receiver stalls, words pile up in
// the stages; input is still taken while any stage holds a bubble, and
// in_ready_o drops only once every stage is full.
module clock_period_unit_converter_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cpuc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [cpuc_pkg::PeriodW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [cpuc_pkg::ActionW-1:0] action_i,
  input  logic                         clock_select_i,
  input  logic [cpuc_pkg::AmountW-1:0] amount_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [cpuc_pkg::AmountW-1:0] converted_o
);
  import cpuc_pkg::*;

  cfg_t cfg_q;
  logic cell_valid [NumCells+1];
  logic cell_ready [NumCells+1];
  div_t cell_data  [NumCells+1];
  div_t last;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgInfoPresent: cfg_q.info_present <= cfg_data_i[0];
        CfgCoreNum:     cfg_q.core_num     <= cfg_data_i;
        CfgCoreDen:     cfg_q.core_den     <= cfg_data_i;
        CfgRefNum:      cfg_q.ref_num      <= cfg_data_i;
        CfgRefDen:      cfg_q.ref_den      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  cpuc_mul u_mul (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .clock_select_i (clock_select_i),
    .amount_i       (amount_i),
    .out_valid_o    (cell_valid[0]),
    .out_ready_i    (cell_ready[0]),
    .out_data_o     (cell_data[0])
  );

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    cpuc_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (cell_valid[k]),
      .in_ready_o  (cell_ready[k]),
      .in_data_i   (cell_data[k]),
      .out_valid_o (cell_valid[k+1]),
      .out_ready_i (cell_ready[k+1]),
      .out_data_o  (cell_data[k+1])
    );
  end

  assign last                 = cell_data[NumCells];
  assign out_valid_o          = cell_valid[NumCells];
  assign cell_ready[NumCells] = out_ready_i;

  // frequency results keep only the low 32 quotient bits
  always_comb begin
    if (last.zero) begin
      converted_o = '0;
    end else if (last.mask) begin
      converted_o = {{HalfW{1'b0}}, last.dvd[HalfW-1:0]};
    end else begin
      converted_o = last.dvd;
    end
  end

  // input stalls only when the whole pipeline is backed up to the output
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // a word entering the divider chain unflagged has a nonzero divisor
  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid[0] && !cell_data[0].zero) |-> (cell_data[0].div != '0))
    else $error("zero divisor reached the divider unflagged");

  // a result held by the receiver is not dropped from the last cell
  a_hold_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("stalled result lost");

endmodule

>>> rtl/cpuc_mul.sv
// operand select and two-stage 64x16 wrapping multiply feeding the divider chain
module cpuc_mul (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cpuc_pkg::cfg_t                   cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [cpuc_pkg::ActionW-1:0]     action_i,
  input  logic                             clock_select_i,
  input  logic [cpuc_pkg::AmountW-1:0]     amount_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output cpuc_pkg::div_t                   out_data_o
);
  import cpuc_pkg::*;

  logic [PeriodW-1:0] num, den, mul_op, div_op;
  logic [AmountW-1:0] a_op;
  logic               bad_action;
  mul_t               s1_d, s1_q;
  logic               s1_valid_q, s1_ready;
  div_t               s2_d, s2_q;
  logic               s2_valid_q, s2_ready;

  always_comb begin
    num        = clock_select_i ? cfg_i.ref_num : cfg_i.core_num;
    den        = clock_select_i ? cfg_i.ref_den : cfg_i.core_den;
    a_op       = amount_i;
    mul_op     = num;
    div_op     = den;
    bad_action = 1'b0;
    case (action_e'(action_i))
      ActCyclesToNs: begin
        mul_op = num;
        div_op = den;
      end
      ActNsToCycles: begin
        mul_op = den;
        div_op = num;
      end
      ActFreq: begin
        a_op   = {{HalfW{1'b0}}, HzPerGhz};
        mul_op = den;
        div_op = num;
      end
      default: begin
        bad_action = 1'b1;
      end
    endcase
    s1_d.lo   = a_op[HalfW-1:0] * mul_op;
    // upper half only matters modulo 2^32 once shifted up
    s1_d.hi   = a_op[AmountW-1:HalfW] * mul_op;
    s1_d.div  = div_op;
    s1_d.zero = !cfg_i.info_present || (div_op == '0) || bad_action;
    s1_d.mask = (action_e'(action_i) == ActFreq);
  end

  always_comb begin
    s2_d.dvd  = AmountW'(s1_q.lo) + {s1_q.hi, {HalfW{1'b0}}};
    s2_d.rem  = '0;
    s2_d.div  = s1_q.div;
    s2_d.zero = s1_q.zero;
    s2_d.mask = s1_q.mask;
  end

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (s2_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_q;

endmodule

>>> rtl/cpuc_div_cell.sv
// one divider cell: CellBits (4) restoring quotient bits per word, then a register
module cpuc_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cpuc_pkg::div_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cpuc_pkg::div_t out_data_o
);
  import cpuc_pkg::*;

  div_t nxt, data_q;
  logic valid_q;

  always_comb begin
    logic [PeriodW:0] r;
    logic             qb;
    nxt = in_data_i;
    for (int i = 0; i < CellBits; i++) begin
      r  = {nxt.rem, nxt.dvd[AmountW-1]};
      qb = (r >= {1'b0, nxt.div});
      if (qb) begin
        r = r - {1'b0, nxt.div};
      end
      nxt.rem = r[PeriodW-1:0];
      nxt.dvd = {nxt.dvd[AmountW-2:0], qb};
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= nxt;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

>>> dv/tb_top.sv
// testbench for the clock period unit converter: directed and random words, local predictor
`timescale 1ns / 1ps

module tb_top;
  import cpuc_pkg::*;

  localparam logic [ActionW-1:0] ActReserved = 2'd3;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned MaxPrints   = 100;
  localparam int unsigned PhaseCount  = 10;
  localparam int unsigned PhaseWords  = 70;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned FloodWords  = 60;

  typedef struct {
    logic [ActionW-1:0] act;
    logic               sel;
    logic [AmountW-1:0] amount;
    logic [AmountW-1:0] converted;
  } conversion_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [PeriodW-1:0] cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [ActionW-1:0] action_i;
  logic               clock_select_i;
  logic [AmountW-1:0] amount_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [AmountW-1:0] converted_o;

  cfg_t        period_cfg;
  conversion_t pending_conversions[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          sender_gaps;
  bit          sink_stalls;
  int unsigned sink_hold_req;
  int unsigned sink_stall_left;
  int unsigned sink_pick;

  clock_period_unit_converter_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .clock_select_i (clock_select_i),
    .amount_i       (amount_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .converted_o    (converted_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  // expected conversion of one word under the current register copy
  function automatic logic [AmountW-1:0] predict_converted(input logic [ActionW-1:0] act,
                                                           input logic sel,
                                                           input logic [AmountW-1:0] amount);
    logic [AmountW-1:0] num;
    logic [AmountW-1:0] den;
    logic [AmountW-1:0] quot;
    num = AmountW'(sel ? period_cfg.ref_num : period_cfg.core_num);
    den = AmountW'(sel ? period_cfg.ref_den : period_cfg.core_den);
    if (!period_cfg.info_present) return '0;
    case (act)
      ActCyclesToNs: begin
        if (den == '0) return '0;
        return (amount * num) / den;
      end
      ActNsToCycles: begin
        if (num == '0) return '0;
        return (amount * den) / num;
      end
      ActFreq: begin
        if (num == '0) return '0;
        quot = (den * AmountW'(HzPerGhz)) / num;
        return {{HalfW{1'b0}}, quot[HalfW-1:0]};
      end
      default: return '0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input conversion_t exp_word,
                                 input logic [AmountW-1:0] got);
    if (mismatches < MaxPrints) begin
      $display("%0t: %s: act=%0d sel=%0d amount=%h got=%h want=%h", $realtime, what,
               exp_word.act, exp_word.sel, exp_word.amount, got, exp_word.converted);
    end
    mismatches++;
  endtask

  // leaves cfg_valid_i high so back-to-back writes never lower and raise it in one step
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PeriodW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgInfoPresent: period_cfg.info_present = data[0];
      CfgCoreNum:     period_cfg.core_num     = data;
      CfgCoreDen:     period_cfg.core_den     = data;
      CfgRefNum:      period_cfg.ref_num      = data;
      CfgRefDen:      period_cfg.ref_den      = data;
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_conversions.size() != 0) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [PeriodW-1:0] info, input logic [PeriodW-1:0] core_num,
                              input logic [PeriodW-1:0] core_den,
                              input logic [PeriodW-1:0] ref_num,
                              input logic [PeriodW-1:0] ref_den);
    wait_drain();
    write_reg(CfgInfoPresent, info);
    write_reg(CfgCoreNum, core_num);
    write_reg(CfgCoreDen, core_den);
    write_reg(CfgRefNum, ref_num);
    write_reg(CfgRefDen, ref_den);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!sender_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_word(input logic [ActionW-1:0] act, input logic sel,
                           input logic [AmountW-1:0] amount);
    int unsigned gap;
    conversion_t exp_word;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    clock_select_i <= sel;
    amount_i       <= amount;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    exp_word.act       = act;
    exp_word.sel       = sel;
    exp_word.amount    = amount;
    exp_word.converted = predict_converted(act, sel, amount);
    pending_conversions.push_back(exp_word);
  endtask

  function automatic logic [PeriodW-1:0] rand_period();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 16'd1;
      3: return PeriodW'($urandom_range(1, 16));
      default: return PeriodW'($urandom);
    endcase
  endfunction

  function automatic logic [AmountW-1:0] rand_amount();
    logic [AmountW-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: return AmountW'($urandom_range(0, 1000));
      1: return v >> $urandom_range(0, AmountW - 1);
      2: return $urandom_range(0, 1) ? '1 : (64'd1 << $urandom_range(0, AmountW - 1));
      default: return v;
    endcase
  endfunction

  task automatic send_random_word();
    logic [ActionW-1:0] act;
    act = ($urandom_range(0, 19) == 0) ? ActReserved : ActionW'($urandom_range(0, 2));
    send_word(act, 1'($urandom), rand_amount());
  endtask

  // registers at reset, and with the info bit cleared while upper data bits are set
  task automatic test_info_absent();
    send_word(ActCyclesToNs, 1'b0, '1);
    send_word(ActNsToCycles, 1'b1, '1);
    send_word(ActFreq, 1'b0, '0);
    send_word(ActReserved, 1'b1, 64'h1234);
    apply_config(16'hfffe, 16'd10, 16'd3, 16'd7, 16'd2);
    send_word(ActCyclesToNs, 1'b0, 64'd100);
    send_word(ActFreq, 1'b1, '0);
  endtask

  task automatic test_directed();
    apply_config(16'd1, 16'd5, 16'd2, 16'd1, 16'd1);
    send_word(ActCyclesToNs, 1'b0, 64'd7);
    send_word(ActNsToCycles, 1'b0, '0);
    send_word(ActCyclesToNs, 1'b0, '1);
    send_word(ActFreq, 1'b1, '1);
    send_word(ActReserved, 1'b0, 64'd99);
    // widest ratios: product wraps and frequency loses its upper bits
    apply_config(16'd1, 16'hffff, 16'h0001, 16'h0001, 16'hffff);
    send_word(ActFreq, 1'b1, '0);
    send_word(ActFreq, 1'b0, '0);
    send_word(ActCyclesToNs, 1'b0, 64'h8000_0000_0000_0000);
    send_word(ActNsToCycles, 1'b1, '1);
    send_word(ActCyclesToNs, 1'b1, '1);
    // zero divisor on each side
    apply_config(16'd1, 16'd3, 16'd0, 16'd0, 16'd7);
    send_word(ActCyclesToNs, 1'b0, 64'd12345);
    send_word(ActNsToCycles, 1'b0, 64'd12345);
    send_word(ActFreq, 1'b0, '0);
    send_word(ActNsToCycles, 1'b1, 64'd12345);
    send_word(ActFreq, 1'b1, '0);
    send_word(ActCyclesToNs, 1'b1, '1);
    apply_config(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_word(ActCyclesToNs, 1'b0, '1);
    send_word(ActFreq, 1'b1, 64'd5);
  endtask

  task automatic test_ignored_index();
    apply_config(16'd1, 16'd7, 16'd3, 16'd11, 16'd5);
    // an idle wait on the clock so cfg_valid_i is not lowered and raised in the same step
    @(posedge clk_i);
    for (int i = int'(CfgRefDen) + 1; i < 2 ** CfgIdxW; i++) begin
      write_reg(CfgIdxW'(i), PeriodW'($urandom));
    end
    cfg_valid_i <= 1'b0;
    send_word(ActCyclesToNs, 1'b0, 64'd1000);
    send_word(ActNsToCycles, 1'b1, 64'd1000);
    send_word(ActFreq, 1'b0, '0);
    send_word(ActFreq, 1'b1, '0);
  endtask

  task automatic test_random();
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: apply_config(16'd1, '1, '1, '1, '1);
        1: apply_config(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        2: apply_config(16'd0, rand_period(), rand_period(), rand_period(), rand_period());
        default: apply_config(PeriodW'($urandom_range(1, 3)), rand_period(), rand_period(),
                              rand_period(), rand_period());
      endcase
      // every third phase runs with no idling on either side
      sender_gaps = (phase % 3 != 2);
      sink_stalls = (phase % 3 != 2);
      repeat (PhaseWords) send_random_word();
    end
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // receiver holds off long enough that the pipeline fills and input stalls
  task automatic test_backpressure();
    apply_config(16'd1, rand_period(), PeriodW'($urandom_range(1, 65535)), rand_period(),
                 PeriodW'($urandom_range(1, 65535)));
    sink_hold_req = HoldCycles;
    sender_gaps   = 1'b0;
    repeat (FloodWords) send_random_word();
    sender_gaps   = 1'b1;
  endtask

  always @(posedge clk_i) begin
    if (sink_hold_req > 0) begin
      sink_stall_left = sink_hold_req;
      sink_hold_req   = 0;
    end
    if (sink_stall_left > 0) begin
      out_ready_i <= 1'b0;
      sink_stall_left--;
    end else if (!sink_stalls) begin
      out_ready_i <= 1'b1;
    end else begin
      sink_pick = $urandom_range(0, 99);
      if (sink_pick < 70) begin
        out_ready_i <= 1'b1;
      end else if (sink_pick < 95) begin
        out_ready_i     <= 1'b0;
        sink_stall_left = $urandom_range(0, 2);
      end else begin
        out_ready_i     <= 1'b0;
        sink_stall_left = $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    conversion_t exp_word;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_conversions.size() == 0) begin
        exp_word = '{act: '0, sel: 1'b0, amount: '0, converted: '0};
        report_mismatch("unexpected word", exp_word, converted_o);
      end else begin
        exp_word = pending_conversions.pop_front();
        if (converted_o !== exp_word.converted) begin
          report_mismatch("converted mismatch", exp_word, converted_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    period_cfg      = '0;
    mismatches      = 0;
    idle_cycles     = 0;
    sender_gaps     = 1'b1;
    sink_stalls     = 1'b1;
    sink_hold_req   = 0;
    sink_stall_left = 0;
    rst_ni         <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= '0;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    action_i       <= '0;
    clock_select_i <= 1'b0;
    amount_i       <= '0;
    out_ready_i    <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_info_absent();
    test_directed();
    test_ignored_index();
    test_random();
    test_backpressure();

    wait_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_conversions.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
